// File: rtl/grnf_pkg.sv
// Shared types and constants for the glyph raster to nibble framebuffer block.
// Holds the sequencer state type, request function codes and nibble masks.
// No dependencies.
`timescale 1ns / 1ps

package grnf_pkg;

  // Default build limits of the panel and of the frame store.
  localparam int MAX_WIDTH_DEFAULT   = 256;
  localparam int MAX_HEIGHT_DEFAULT  = 64;
  localparam int FRAME_BYTES_DEFAULT = 8192;

  // Widths of the configuration registers and of signed pixel coordinates.
  localparam int BUF_WIDTH_BITS  = 9;
  localparam int BUF_HEIGHT_BITS = 7;
  localparam int COORD_WIDTH     = 14;

  // Reset values of the configuration registers.
  localparam logic [BUF_WIDTH_BITS-1:0]  BUF_WIDTH_RESET  = 9'd256;
  localparam logic [BUF_HEIGHT_BITS-1:0] BUF_HEIGHT_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic REG_BUFFER_WIDTH  = 1'b0;
  localparam logic REG_BUFFER_HEIGHT = 1'b1;

  // Nibble masks used in the read-modify-write of a framebuffer byte.
  localparam logic [7:0] NIBBLE_HI = 8'hF0;
  localparam logic [7:0] NIBBLE_LO = 8'h0F;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_GLYPH  = 2'd0,
    FUNC_BITMAP = 2'd1,
    FUNC_PIXEL  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_RDATA,
    ST_RESP
  } state_t;

  // Status of the pixel address unit.
  typedef struct packed {
    logic ok;   // pixel lies inside the panel and inside the frame store
    logic low;  // pixel lives in the low nibble of its byte
  } pix_status_t;

endpackage

// File: rtl/grnf_pixel_unit.sv
// Shared pixel address unit: clips a coordinate and forms its byte address.
// Depends on grnf_pkg for the coordinate width and the status struct.
`timescale 1ns / 1ps

module grnf_pixel_unit import grnf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEFAULT,
  parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT,
  localparam int XW = (BUF_WIDTH_BITS > $clog2(MAX_WIDTH + 1)) ?
                      BUF_WIDTH_BITS : $clog2(MAX_WIDTH + 1),
  localparam int YW = (BUF_HEIGHT_BITS > $clog2(MAX_HEIGHT + 1)) ?
                      BUF_HEIGHT_BITS : $clog2(MAX_HEIGHT + 1),
  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic [XW-1:0]                 w_eff,
  input  logic [YW-1:0]                 h_eff,
  output pix_status_t                   status,
  output logic [AW-1:0]                 addr
);

  localparam int PW = XW + YW;
  localparam int LW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic          in_r;
  logic [PW-1:0] prod_r;
  logic [XW-1:0] x_r;
  logic          in_next;
  logic [LW-1:0] lin;
  logic [LW-1:0] idx;

  // Clip against the effective panel size.
  always_comb begin
    in_next = !x[COORD_WIDTH-1] && !y[COORD_WIDTH-1] &&
              ($unsigned(x) < COORD_WIDTH'(w_eff)) &&
              ($unsigned(y) < COORD_WIDTH'(h_eff));
  end

  // First step: register the clip result and the row product y * width.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_r <= 1'b0;
    end else if (load) begin
      in_r <= in_next;
    end
    if (load) begin
      prod_r <= PW'($unsigned(y)) * PW'(w_eff);
      x_r    <= XW'($unsigned(x));
    end
  end

  // Second step: linear index, byte index and the frame store bound.
  always_comb begin
    lin        = LW'(prod_r) + LW'(x_r);
    idx        = lin >> 1;
    status.ok  = in_r && (32'(idx) < 32'(FRAME_BYTES));
    status.low = lin[0];
    addr       = AW'(idx);
  end

endmodule

// File: rtl/glyph_raster_to_nibble_framebuffer.sv
// Top level of the glyph blitter over a 4-bit-per-pixel framebuffer.
// Sequence: glyph start and stray byte go straight to the result strobe; a pixel write
// passes ST_ADDR, ST_WRITE, a clipped one only ST_ADDR; a byte read ST_READ, ST_RDATA,
// none when out of range; a bitmap byte passes ST_BIT per bit, and per set bit ST_ADDR
// and, unless clipped, ST_WRITE, the read-modify-write on the single-port frame store.
// A new request is taken the cycle after the strobe. The receiver cannot stall results.
// Reset: synchronous; a clearing pass zeroes every byte of the store, busy high.
`timescale 1ns / 1ps

module glyph_raster_to_nibble_framebuffer import grnf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEFAULT,
  parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic [11:0]               pos_x,
  input  logic [11:0]               pos_y,
  input  logic [7:0]                glyph_width,
  input  logic [7:0]                glyph_height,
  input  logic signed [7:0]         offset_x,
  input  logic signed [7:0]         offset_y,
  input  logic [3:0]                shade,
  input  logic [7:0]                bitmap_byte,
  input  logic [12:0]               read_address,
  output logic                      result_valid,
  output logic [7:0]                read_data,
  output logic [3:0]                pixels_written,
  output logic                      glyph_done,
  output logic                      stray_byte,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [BUF_WIDTH_BITS-1:0] cfg_data
);

  localparam int XW = (BUF_WIDTH_BITS > $clog2(MAX_WIDTH + 1)) ?
                      BUF_WIDTH_BITS : $clog2(MAX_WIDTH + 1);
  localparam int YW = (BUF_HEIGHT_BITS > $clog2(MAX_HEIGHT + 1)) ?
                      BUF_HEIGHT_BITS : $clog2(MAX_HEIGHT + 1);
  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  state_t                        state;
  state_t                        state_next;
  logic [AW-1:0]                 clr_addr;
  logic [BUF_WIDTH_BITS-1:0]     buffer_width;
  logic [BUF_HEIGHT_BITS-1:0]    buffer_height;
  logic signed [COORD_WIDTH-1:0] base_x;
  logic signed [COORD_WIDTH-1:0] base_y;
  logic [7:0]                    gw;
  logic [7:0]                    gh;
  logic [3:0]                    glyph_shade;
  logic [7:0]                    col;
  logic [7:0]                    row;
  logic                          glyph_active;
  logic [7:0]                    sr;
  logic [2:0]                    bit_cnt;
  logic                          glyph_mode;
  logic [3:0]                    pix_shade;
  logic [AW-1:0]                 wr_addr;
  logic                          wr_low;
  logic [AW-1:0]                 rd_addr;

  logic                          accept;
  logic                          clr_last;
  logic                          col_last;
  logic                          row_last;
  logic                          step;
  logic                          step_last;
  logic [3:0]                    cur_shade;
  logic [XW-1:0]                 w_eff;
  logic [YW-1:0]                 h_eff;
  logic                          pix_load;
  logic signed [COORD_WIDTH-1:0] pix_x;
  logic signed [COORD_WIDTH-1:0] pix_y;
  pix_status_t                   pix_status;
  logic [AW-1:0]                 pix_addr;

  logic [7:0]                    frame_store [FRAME_BYTES];
  logic                          mem_we;
  logic [AW-1:0]                 mem_addr;
  logic [7:0]                    mem_wdata;
  logic [7:0]                    mem_rdata;

  assign accept    = start && !busy;
  assign clr_last  = (clr_addr == AW'(FRAME_BYTES - 1));
  assign col_last  = ({1'b0, col} + 9'd1) == {1'b0, gw};
  assign row_last  = ({1'b0, row} + 9'd1) == {1'b0, gh};
  assign step_last = (bit_cnt == 3'd7) || (col_last && row_last);
  assign cur_shade = glyph_mode ? glyph_shade : pix_shade;
  assign cfg_ready = 1'b1;

  // Effective panel size: the register clamped to the synthesized maximum.
  always_comb begin
    w_eff = (XW'(buffer_width) < XW'(MAX_WIDTH)) ? XW'(buffer_width) : XW'(MAX_WIDTH);
    h_eff = (YW'(buffer_height) < YW'(MAX_HEIGHT)) ? YW'(buffer_height) : YW'(MAX_HEIGHT);
  end

  // One bit of the glyph stream is retired: clear bit, clipped pixel or finished write.
  always_comb begin
    step = ((state == ST_BIT) && !sr[7]) ||
           ((state == ST_ADDR) && !pix_status.ok && glyph_mode) ||
           ((state == ST_WRITE) && glyph_mode);
  end

  // Feed the pixel unit from a single-pixel request or from the glyph cursor.
  always_comb begin
    pix_load = ((state == ST_IDLE) && accept && (func_t'(func) == FUNC_PIXEL)) ||
               ((state == ST_BIT) && sr[7]);
    if (state == ST_BIT) begin
      pix_x = base_x + $signed(COORD_WIDTH'(col));
      pix_y = base_y + $signed(COORD_WIDTH'(row));
    end else begin
      pix_x = $signed({2'b00, pos_x});
      pix_y = $signed({2'b00, pos_y});
    end
  end

  grnf_pixel_unit #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_pixel (
    .clk    (clk),
    .rst    (rst),
    .load   (pix_load),
    .x      (pix_x),
    .y      (pix_y),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .status (pix_status),
    .addr   (pix_addr)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_GLYPH:  state_next = ST_RESP;
            FUNC_BITMAP: state_next = glyph_active ? ST_BIT : ST_RESP;
            FUNC_PIXEL:  state_next = ST_ADDR;
            FUNC_READ: begin
              state_next = (32'(read_address) < 32'(FRAME_BYTES)) ? ST_READ : ST_RESP;
            end
          endcase
        end
      end
      ST_BIT: begin
        if (sr[7]) state_next = ST_ADDR;
        else       state_next = step_last ? ST_RESP : ST_BIT;
      end
      ST_ADDR: begin
        if (pix_status.ok)   state_next = ST_WRITE;
        else if (glyph_mode) state_next = step_last ? ST_RESP : ST_BIT;
        else                 state_next = ST_RESP;
      end
      ST_WRITE: begin
        if (glyph_mode) state_next = step_last ? ST_RESP : ST_BIT;
        else            state_next = ST_RESP;
      end
      ST_READ:  state_next = ST_RDATA;
      ST_RDATA: state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and frame store port.
  always_comb begin
    busy         = (state != ST_IDLE);
    result_valid = (state == ST_RESP);
    mem_we       = 1'b0;
    mem_addr     = rd_addr;
    mem_wdata    = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_ADDR: mem_addr = pix_addr;
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = wr_addr;
        if (wr_low) mem_wdata = (mem_rdata & NIBBLE_HI) | {4'b0000, cur_shade};
        else        mem_wdata = (mem_rdata & NIBBLE_LO) | {cur_shade, 4'b0000};
      end
      default: mem_addr = rd_addr;
    endcase
  end

  // Single-port frame store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) frame_store[mem_addr] <= mem_wdata;
    mem_rdata <= frame_store[mem_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= BUF_WIDTH_RESET;
      buffer_height <= BUF_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUFFER_WIDTH:  buffer_width  <= cfg_data;
        REG_BUFFER_HEIGHT: buffer_height <= cfg_data[BUF_HEIGHT_BITS-1:0];
      endcase
    end
  end

  // Control state: sequencer, clearing pass and glyph cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      glyph_active <= 1'b0;
      col          <= '0;
      row          <= '0;
      bit_cnt      <= '0;
      glyph_mode   <= 1'b0;
      base_x       <= '0;
      base_y       <= '0;
      gw           <= '0;
      gh           <= '0;
      glyph_shade  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);

      // Latch a new glyph; this abandons any glyph still active.
      if (accept && (func_t'(func) == FUNC_GLYPH)) begin
        base_x       <= $signed({2'b00, pos_x}) + COORD_WIDTH'(offset_x);
        base_y       <= $signed({2'b00, pos_y}) + COORD_WIDTH'(offset_y);
        gw           <= glyph_width;
        gh           <= glyph_height;
        glyph_shade  <= shade;
        col          <= '0;
        row          <= '0;
        glyph_active <= (glyph_width != 8'd0) && (glyph_height != 8'd0);
      end

      if (accept) begin
        glyph_mode <= (func_t'(func) == FUNC_BITMAP);
        bit_cnt    <= '0;
      end

      // Advance the glyph cursor by one bit, wrapping at the row end.
      if (step) begin
        bit_cnt <= bit_cnt + 3'd1;
        if (col_last) begin
          col <= '0;
          row <= row + 8'd1;
          if (row_last) glyph_active <= 1'b0;
        end else begin
          col <= col + 8'd1;
        end
      end
    end
  end

  // Request payload and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= '0;
      pixels_written <= '0;
      glyph_done     <= (func_t'(func) == FUNC_GLYPH) &&
                        ((glyph_width == 8'd0) || (glyph_height == 8'd0));
      stray_byte     <= (func_t'(func) == FUNC_BITMAP) && !glyph_active;
      sr             <= bitmap_byte;
      pix_shade      <= shade;
      rd_addr        <= AW'(read_address);
    end
    if (step) begin
      sr <= {sr[6:0], 1'b0};
      if (col_last && row_last) glyph_done <= 1'b1;
    end
    if (state == ST_ADDR) begin
      wr_addr <= pix_addr;
      wr_low  <= pix_status.low;
    end
    if (state == ST_WRITE) pixels_written <= pixels_written + 4'd1;
    if (state == ST_RDATA) read_data <= mem_rdata;
  end

`ifndef SYNTHESIS
  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after an accepted request");

  // Outside the clearing pass, the frame store is only written at pixels that passed clipping.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> pix_status.ok)
    else $error("write to a clipped pixel");

  // The glyph column stays inside the glyph while a glyph is active.
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    glyph_active |-> ({1'b0, col} < {1'b0, gw}))
    else $error("glyph column beyond glyph width");

  // One bitmap byte writes at most eight pixels.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pixels_written <= 4'd8))
    else $error("pixel count beyond eight");
`endif

endmodule
